>>> src/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/tfs_pkg.sv
// Types and constants of the timed frame scheduler.
`timescale 1ns / 1ps

package tfs_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int LOSS_MAX    = MAX_RESULTS - 1;

    typedef enum logic [1:0] {
        KIND_ACCEPTED   = 2'd0,
        KIND_REJECTED   = 2'd1,
        KIND_LOST       = 2'd2,
        KIND_DISPATCHED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_SCAN,
        ST_SWEEP,
        ST_DISPATCH
    } state_t;

    typedef struct packed {
        logic [3:0]  sender;
        logic [31:0] can_id;
        logic [15:0] frame_tag;
        logic [63:0] deadline;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic drop;
        logic load;
    } cell_ctrl_t;

endpackage

>>> src/tfs_req_if.sv
// Request channel: enqueue and tick items.
`timescale 1ns / 1ps

interface tfs_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  sender;
    logic [31:0] can_id;
    logic [15:0] frame_tag;
    logic [1:0]  frame_count;
    logic [63:0] delay;
    logic [63:0] now;

    modport source (output valid, mode, sender, can_id, frame_tag, frame_count, delay, now,
                    input ready);
    modport sink (input valid, mode, sender, can_id, frame_tag, frame_count, delay, now,
                  output ready);
endinterface

>>> src/tfs_rsp_if.sv
// Result channel: one item per scheduler result.
`timescale 1ns / 1ps

interface tfs_rsp_if;
    logic           valid;
    logic           ready;
    tfs_pkg::kind_t kind;
    logic [3:0]     out_sender;
    logic [31:0]    out_can_id;
    logic [15:0]    out_frame_tag;
    logic [63:0]    out_deadline;
    logic           last;

    modport source (output valid, kind, out_sender, out_can_id, out_frame_tag,
                    out_deadline, last, input ready);
    modport sink (input valid, kind, out_sender, out_can_id, out_frame_tag,
                  out_deadline, last, output ready);
endinterface

>>> src/tfs_cell.sv
// One queue slot: loads a new entry or rotates with its neighbors.
`timescale 1ns / 1ps

module tfs_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic                clk,
    input  tfs_pkg::cell_ctrl_t ctrl,
    input  logic [IW-1:0]       tail,
    input  logic [IW-1:0]       load_idx,
    input  tfs_pkg::entry_t     new_entry,
    input  tfs_pkg::entry_t     head,
    input  tfs_pkg::entry_t     nbr,
    output tfs_pkg::entry_t     q
);

    tfs_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && load_idx == IW'(IDX))
        begin
            entry_reg <= new_entry;
        end
        else if (ctrl.shift)
        begin
            // the tail slot takes the head back unless the head is dropped
            if (!ctrl.drop && tail == IW'(IDX))
                entry_reg <= head;
            else
                entry_reg <= nbr;
        end
    end

    assign q = entry_reg;

endmodule

>>> src/timed_frame_scheduler_core.sv
// An enqueue goes through the ENQ state to a registered result; a tick with work makes
// one rotation pass over the N queued entries to select, and one to report and remove.
// Throughput is one item at a time: a new item is taken only in the idle state.
// A tick with an empty queue or now < wake ends in its accept cycle with no result.
// rst_n (async, low) empties the queue and clears the wake time; slots need no clear.
`timescale 1ns / 1ps

module timed_frame_scheduler_core #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int CLIENT_COUNT = 16
) (
    input logic      clk,
    input logic      rst_n,
    tfs_req_if.sink  req,
    tfs_rsp_if.source rsp
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    tfs_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   sel_reg, sel_next;
    logic [3:0]      nres_reg, nres_next;
    logic [63:0]     wake_reg, wake_next;
    logic [63:0]     now_reg, now_next;
    logic [1:0]      fc_reg, fc_next;
    tfs_pkg::entry_t in_reg, in_next;
    tfs_pkg::entry_t best_reg, best_next;
    logic            best_due_reg, best_due_next;

    logic            out_valid_reg, out_valid_next;
    tfs_pkg::kind_t  out_kind_reg, out_kind_next;
    tfs_pkg::entry_t out_entry_reg, out_entry_next;
    logic            out_last_reg, out_last_next;

    tfs_pkg::entry_t    cell_q [QUEUE_DEPTH];
    tfs_pkg::entry_t    head;
    tfs_pkg::cell_ctrl_t ctrl;
    logic [IW-1:0]      tail;
    logic [IW-1:0]      load_idx;
    logic               out_free;
    logic               head_due;
    logic               head_beats;
    logic               enq_ok;
    logic               in_acc;

    assign head     = cell_q[0];
    assign tail     = IW'(count_reg - CW'(1));
    assign load_idx = count_reg[IW-1:0];
    assign out_free = !out_valid_reg || rsp.ready;
    assign head_due = head.deadline <= now_reg;
    assign head_beats = (head_due != best_due_reg) ? head_due :
                        (head.deadline != best_reg.deadline) ?
                            (head.deadline < best_reg.deadline) :
                            (head.can_id < best_reg.can_id);
    assign enq_ok = (fc_reg == 2'd1) && (32'(in_reg.sender) < CLIENT_COUNT)
                    && (32'(count_reg) < QUEUE_DEPTH);
    assign req.ready = (state_reg == tfs_pkg::ST_IDLE);
    assign in_acc    = req.valid && req.ready;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            tfs_cell #(
                .IDX (gi),
                .IW  (IW)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .tail      (tail),
                .load_idx  (load_idx),
                .new_entry (in_reg),
                .head      (head),
                .nbr       (cell_q[(gi + 1 < QUEUE_DEPTH) ? gi + 1 : gi]),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tfs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        sel_next       = sel_reg;
        nres_next      = nres_reg;
        wake_next      = wake_reg;
        now_next       = now_reg;
        fc_next        = fc_reg;
        in_next        = in_reg;
        best_next      = best_reg;
        best_due_next  = best_due_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        unique case (state_reg)
            tfs_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    in_next.sender    = req.sender;
                    in_next.can_id    = req.can_id;
                    in_next.frame_tag = req.frame_tag;
                    in_next.deadline  = req.now + req.delay;
                    fc_next           = req.frame_count;
                    now_next          = req.now;
                    pos_next          = '0;
                    nres_next         = '0;
                    n_next            = count_reg;
                    if (!req.mode)
                        state_next = tfs_pkg::ST_ENQ;
                    else if (count_reg != '0 && req.now >= wake_reg)
                        state_next = tfs_pkg::ST_SCAN;
                end
            end
            tfs_pkg::ST_ENQ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = in_reg;
                    out_last_next  = 1'b1;
                    out_kind_next  = enq_ok ? tfs_pkg::KIND_ACCEPTED : tfs_pkg::KIND_REJECTED;
                    if (enq_ok)
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0)
                            wake_next = in_reg.deadline;
                    end
                    state_next = tfs_pkg::ST_IDLE;
                end
            end
            tfs_pkg::ST_SCAN:
            begin
                // rotate once around, keeping the best head seen
                ctrl.shift = 1'b1;
                if (pos_reg == '0 || head_beats)
                begin
                    best_next     = head;
                    best_due_next = head_due;
                    sel_next      = pos_reg;
                end
                pos_next = pos_reg + CW'(1);
                if (pos_reg == n_reg - CW'(1))
                begin
                    pos_next   = '0;
                    state_next = tfs_pkg::ST_SWEEP;
                end
            end
            tfs_pkg::ST_SWEEP:
            begin
                if (pos_reg == sel_reg)
                begin
                    ctrl.shift = 1'b1;
                    ctrl.drop  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else if (head.deadline == best_reg.deadline && 32'(nres_reg) < tfs_pkg::LOSS_MAX)
                begin
                    if (out_free)
                    begin
                        ctrl.shift     = 1'b1;
                        out_valid_next = 1'b1;
                        out_entry_next = head;
                        out_kind_next  = tfs_pkg::KIND_LOST;
                        out_last_next  = 1'b0;
                        nres_next      = nres_reg + 4'd1;
                    end
                end
                else
                begin
                    ctrl.shift = 1'b1;
                end
                if (ctrl.shift)
                begin
                    pos_next = pos_reg + CW'(1);
                    if (pos_reg == n_reg - CW'(1))
                        state_next = tfs_pkg::ST_DISPATCH;
                end
            end
            tfs_pkg::ST_DISPATCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = best_reg;
                    out_kind_next  = tfs_pkg::KIND_DISPATCHED;
                    out_last_next  = 1'b1;
                    if (count_reg != '0)
                        wake_next = head.deadline;
                    state_next = tfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wake_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            wake_reg      <= wake_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        pos_reg       <= pos_next;
        sel_reg       <= sel_next;
        nres_reg      <= nres_next;
        now_reg       <= now_next;
        fc_reg        <= fc_next;
        in_reg        <= in_next;
        best_reg      <= best_next;
        best_due_reg  <= best_due_next;
        out_kind_reg  <= out_kind_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.out_sender    = out_entry_reg.sender;
    assign rsp.out_can_id    = out_entry_reg.can_id;
    assign rsp.out_frame_tag = out_entry_reg.frame_tag;
    assign rsp.out_deadline  = out_entry_reg.deadline;
    assign rsp.last          = out_last_reg;

endmodule

>>> src/tfs_checker.sv
// Port-level checks on the scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           req_mode,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input tfs_pkg::kind_t rsp_kind,
    input logic           rsp_last
);

    `TFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `TFS_ASSERT_NOW(a_enq_last, rsp_valid && (rsp_kind == tfs_pkg::KIND_ACCEPTED || rsp_kind == tfs_pkg::KIND_REJECTED), rsp_last)
    `TFS_ASSERT_NOW(a_lost_not_last, rsp_valid && rsp_kind == tfs_pkg::KIND_LOST, !rsp_last)
    `TFS_ASSERT_NEXT(a_enq_busy, req_valid && req_ready && !req_mode, !req_ready)

endmodule

bind timed_frame_scheduler_core tfs_checker u_tfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_mode  (req.mode),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.kind),
    .rsp_last  (rsp.last)
);

>>> sim/tfs_scoreboard.sv
// Result checker for the timed frame scheduler: predicts results and compares them.
`timescale 1ns / 1ps

module tfs_scoreboard #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int CLIENT_COUNT = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    tfs_req_if       req,
    tfs_rsp_if       rsp,
    output int       err_count,
    output int       pending
);

    typedef struct {
        tfs_pkg::kind_t kind;
        logic [3:0]     snd;
        logic [31:0]    id;
        logic [15:0]    tag;
        logic [63:0]    dl;
        logic           fin;
    } result_t;

    tfs_pkg::entry_t frames[$];
    logic [63:0]     wake;
    result_t         due_results[$];

    assign pending = due_results.size();

    function automatic bit outranks(tfs_pkg::entry_t b, tfs_pkg::entry_t a, logic [63:0] t);
        bit bd;
        bit ad;
        bd = b.deadline <= t;
        ad = a.deadline <= t;
        if (bd != ad)
            return bd;
        if (b.deadline != a.deadline)
            return b.deadline < a.deadline;
        return b.can_id < a.can_id;
    endfunction

    task automatic schedule_item();
        logic [63:0]     dl;
        tfs_pkg::entry_t e;
        int              sel;
        int              k;
        result_t         r;
        if (req.mode == 1'b0)
        begin
            dl = req.now + req.delay;
            e = '{req.sender, req.can_id, req.frame_tag, dl};
            r = '{tfs_pkg::KIND_REJECTED, req.sender, req.can_id, req.frame_tag, dl, 1'b1};
            if (req.frame_count == 2'd1 && int'(req.sender) < CLIENT_COUNT
                && frames.size() < QUEUE_DEPTH)
            begin
                if (frames.size() == 0)
                    wake = dl;
                frames.push_back(e);
                r.kind = tfs_pkg::KIND_ACCEPTED;
            end
            due_results.push_back(r);
        end
        else if (frames.size() != 0 && req.now >= wake)
        begin
            sel = 0;
            for (int i = 1; i < frames.size(); i++)
                if (outranks(frames[i], frames[sel], req.now))
                    sel = i;
            k = 0;
            for (int i = 0; i < frames.size() && k < tfs_pkg::MAX_RESULTS - 1; i++)
            begin
                if (i != sel && frames[i].deadline == frames[sel].deadline)
                begin
                    due_results.push_back('{tfs_pkg::KIND_LOST, frames[i].sender,
                        frames[i].can_id, frames[i].frame_tag, frames[i].deadline, 1'b0});
                    k++;
                end
            end
            due_results.push_back('{tfs_pkg::KIND_DISPATCHED, frames[sel].sender,
                frames[sel].can_id, frames[sel].frame_tag, frames[sel].deadline, 1'b1});
            frames.delete(sel);
            if (frames.size() != 0)
                wake = frames[0].deadline;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t x;
        if (!rst_n)
        begin
            frames.delete();
            due_results.delete();
            wake = '0;
            err_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                schedule_item();
            if (rsp.valid && rsp.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    err_count++;
                end
                else
                begin
                    x = due_results.pop_front();
                    if (rsp.kind !== x.kind)
                    begin
                        $error("kind exp %0d got %0d", x.kind, rsp.kind);
                        err_count++;
                    end
                    if (rsp.out_sender !== x.snd)
                    begin
                        $error("out_sender exp %0d got %0d", x.snd, rsp.out_sender);
                        err_count++;
                    end
                    if (rsp.out_can_id !== x.id)
                    begin
                        $error("out_can_id exp %h got %h", x.id, rsp.out_can_id);
                        err_count++;
                    end
                    if (rsp.out_frame_tag !== x.tag)
                    begin
                        $error("out_frame_tag exp %h got %h", x.tag, rsp.out_frame_tag);
                        err_count++;
                    end
                    if (rsp.out_deadline !== x.dl)
                    begin
                        $error("out_deadline exp %h got %h", x.dl, rsp.out_deadline);
                        err_count++;
                    end
                    if (rsp.last !== x.fin)
                    begin
                        $error("last exp %0d got %0d", x.fin, rsp.last);
                        err_count++;
                    end
                end
            end
        end
    end
endmodule

>>> sim/timed_frame_scheduler_core_tb.sv
// Testbench top: drives enqueue and tick items into the scheduler and gives the verdict.
`timescale 1ns / 1ps

module timed_frame_scheduler_core_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   err_count;
    int   pending;
    int   idle_cycles;
    bit   rsp_idle_on;
    bit   req_idle_on;
    bit   hold_rsp;
    logic [63:0] clock_ns;

    tfs_req_if req ();
    tfs_rsp_if rsp ();

    timed_frame_scheduler_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    tfs_scoreboard u_scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .err_count (err_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, or a long hold-off when asked.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rsp = 1'b0;
            end
            rsp.ready <= !(rsp_idle_on && $urandom_range(99) < 36);
        end
    end

    // Count cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic m, logic [3:0] s, logic [31:0] id, logic [15:0] tag,
                             logic [1:0] fc, logic [63:0] dly, logic [63:0] t);
        while (req_idle_on && $urandom_range(99) < 36)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= m;
        req.sender      <= s;
        req.can_id      <= id;
        req.frame_tag   <= tag;
        req.frame_count <= fc;
        req.delay       <= dly;
        req.now         <= t;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic enq(logic [31:0] id, logic [63:0] dly);
        send_item(1'b0, 4'($urandom), id, 16'($urandom), 2'd1, dly, clock_ns);
    endtask

    task automatic tick();
        send_item(1'b1, 4'($urandom), $urandom, 16'($urandom), 2'($urandom), {$urandom,
                  $urandom}, clock_ns);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] dly;
        int          sel;
        req.valid = 1'b0;
        req.mode = 1'b0;
        req.sender = '0;
        req.can_id = '0;
        req.frame_tag = '0;
        req.frame_count = '0;
        req.delay = '0;
        req.now = '0;
        hold_rsp = 1'b0;
        rsp_idle_on = 1'b0;
        req_idle_on = 1'b0;
        idle_cycles = 0;
        clock_ns = 64'd100;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick on empty queue, rejections, extremes, ties, wrap.
        tick();
        send_item(1'b0, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 2'd0, 64'd5, clock_ns);
        send_item(1'b0, 4'h0, 32'h0, 16'h0, 2'd2, 64'd5, clock_ns);
        send_item(1'b0, 4'h3, 32'h1, 16'h1, 2'd3, 64'd5, clock_ns);
        send_item(1'b0, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 2'd1, 64'd50, clock_ns);
        send_item(1'b0, 4'h0, 32'h0000_0000, 16'h0000, 2'd1, 64'd50, clock_ns);
        send_item(1'b0, 4'h5, 32'h0000_0007, 16'h1234, 2'd1, 64'd50, clock_ns);
        send_item(1'b0, 4'h6, 32'h10, 16'h2, 2'd1, 64'd10, clock_ns);  // earlier, wake stays
        tick();                          // now < wake: nothing
        clock_ns = clock_ns + 20;
        tick();                          // now < wake: nothing, though one entry is due
        clock_ns = clock_ns + 40;
        tick();                          // earlier deadline wins; next tick: three-way tie, two losses then dispatch
        tick();
        tick();
        tick();                          // empty again
        send_item(1'b0, 4'h2, 32'h3, 16'h3, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFF0);
        send_item(1'b0, 4'h2, 32'h4, 16'h4, 2'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(1'b1, 4'h0, 32'h0, 16'h0, 2'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(1'b1, 4'h0, 32'h0, 16'h0, 2'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Fill beyond depth while results are held back; rejections when full.
        hold_rsp = 1'b1;
        for (int i = 0; i < 18; i++)
            enq($urandom, 64'($urandom_range(3)));
        clock_ns = clock_ns + 10;
        for (int i = 0; i < 16; i++)
            tick();
        drain();

        // Random: bursts of enqueues with clustered deadlines, ticks advance time.
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        for (int n = 0; n < 390; n++)
        begin
            if (n == 195)
                drain();
            sel = $urandom_range(99);
            if (sel < 48)
            begin
                dly = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                               : 64'($urandom_range(4) * 8);
                send_item(1'b0, 4'($urandom), ($urandom_range(3) == 0) ? 32'($urandom_range(3))
                          : $urandom, 16'($urandom), ($urandom_range(9) == 0) ? 2'($urandom)
                          : 2'd1, dly, clock_ns);
            end
            else
            begin
                clock_ns = clock_ns + 64'($urandom_range(12));
                if ($urandom_range(30) == 0)
                    clock_ns = {$urandom, $urandom};
                tick();
            end
        end
        drain();
        repeat (60) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> timed_frame_scheduler_core.f
+incdir+src
src/tfs_pkg.sv
src/tfs_req_if.sv
src/tfs_rsp_if.sv
src/tfs_cell.sv
src/timed_frame_scheduler_core.sv
src/tfs_checker.sv
sim/tfs_scoreboard.sv
sim/timed_frame_scheduler_core_tb.sv
